### sv/slfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slfd_pkg;

  // default payload buffer depth in bytes
  localparam int PAYLOAD_DEPTH_DEF = 64;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
  localparam logic [1:0] REG_FWD_CHANNEL  = 2'd2;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd3;

  // configuration reset values
  localparam logic [7:0] SYNC_FIRST_RST   = 8'd0;
  localparam logic [7:0] SYNC_SECOND_RST  = 8'd0;
  localparam logic [7:0] FWD_CHANNEL_RST  = 8'd0;
  localparam logic [6:0] LENGTH_LIMIT_RST = 7'd64;

  // item opcodes
  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_LINK_LOST = 1'b1;

  // input beat
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } slfd_in_t;

  // result beat
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_last;
  } slfd_out_t;

  // controller to datapath
  typedef struct packed {
    logic cap_chan;
    logic cap_len_low;
    logic start_frame;
    logic store_byte;
    logic replay_en;
  } slfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic len_ok;
    logic frame_done;
    logic chan_match;
    logic replay_end;
  } slfd_sts_t;

endpackage

`default_nettype wire

### sv/slfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module slfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/slfd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module slfd_ctrl
  import slfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      opcode,
  output logic      item_stall,
  input  slfd_sts_t sts,
  output slfd_cmd_t cmd
);

  localparam logic [2:0] ST_HUNT1  = 3'd0;
  localparam logic [2:0] ST_HUNT2  = 3'd1;
  localparam logic [2:0] ST_CHAN   = 3'd2;
  localparam logic [2:0] ST_LENL   = 3'd3;
  localparam logic [2:0] ST_LENH   = 3'd4;
  localparam logic [2:0] ST_DATA   = 3'd5;
  localparam logic [2:0] ST_REPLAY = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  // input is held off only while the buffer is being replayed
  assign item_stall = (state == ST_REPLAY);
  assign accept     = item_valid && !item_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    if (state == ST_REPLAY) begin
      cmd.replay_en = 1'b1;
      if (sts.replay_end) begin
        state_next = ST_HUNT1;
      end
    end else if (accept) begin
      if (opcode == OP_LINK_LOST) begin
        state_next = ST_HUNT1;
      end else begin
        case (state)
          ST_HUNT2: begin
            if (sts.is_sync2) begin
              state_next = ST_CHAN;
            end else if (sts.is_sync1) begin
              state_next = ST_HUNT2;
            end else begin
              state_next = ST_HUNT1;
            end
          end
          ST_CHAN: begin
            cmd.cap_chan = 1'b1;
            state_next   = ST_LENL;
          end
          ST_LENL: begin
            cmd.cap_len_low = 1'b1;
            state_next      = ST_LENH;
          end
          ST_LENH: begin
            cmd.start_frame = 1'b1;
            state_next      = sts.len_ok ? ST_DATA : ST_HUNT1;
          end
          ST_DATA: begin
            cmd.store_byte = 1'b1;
            if (sts.frame_done) begin
              state_next = sts.chan_match ? ST_REPLAY : ST_HUNT1;
            end
          end
          default: begin
            state_next = sts.is_sync1 ? ST_HUNT2 : ST_HUNT1;
          end
        endcase
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT1;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### sv/slfd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module slfd_datapath
  import slfd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1,
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1),
  localparam int IW = CW + 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic [7:0] rx_byte,
  input  slfd_cmd_t  cmd,
  output slfd_sts_t  sts,
  output logic       result_valid,
  input  logic       result_stall,
  output slfd_out_t  result
);

  // configuration registers
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] fwd_channel;
  logic [6:0] length_limit;

  // frame registers
  logic [7:0]    frame_channel;
  logic [7:0]    len_low;
  logic [CW-1:0] frame_len;
  logic [CW-1:0] stored_cnt;

  // replay registers
  logic [AW-1:0] rd_idx;
  logic          rd_pending;
  logic          rd_last;
  logic [7:0]    rd_data;

  logic [7:0] eff_limit;
  logic       move;
  logic       ren;
  logic       idx_is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first   <= SYNC_FIRST_RST;
      sync_second  <= SYNC_SECOND_RST;
      fwd_channel  <= FWD_CHANNEL_RST;
      length_limit <= LENGTH_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SYNC_FIRST:   sync_first   <= cfg_data;
        REG_SYNC_SECOND:  sync_second  <= cfg_data;
        REG_FWD_CHANNEL:  fwd_channel  <= cfg_data;
        REG_LENGTH_LIMIT: length_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // limit saturated to the buffer depth
  assign eff_limit = ({1'b0, length_limit} > 8'(PAYLOAD_DEPTH)) ? 8'(PAYLOAD_DEPTH)
                                                                : {1'b0, length_limit};

  // status toward the controller
  assign sts.is_sync1   = (rx_byte == sync_first);
  assign sts.is_sync2   = (rx_byte == sync_second);
  assign sts.len_ok     = (rx_byte == 8'd0) && (len_low != 8'd0) && (len_low <= eff_limit);
  assign sts.frame_done = ((IW'(stored_cnt) + IW'(1)) == IW'(frame_len));
  assign sts.chan_match = (frame_channel == fwd_channel);
  assign idx_is_last    = ((IW'(rd_idx) + IW'(1)) == IW'(frame_len));
  assign sts.replay_end = ren && idx_is_last;

  // header capture and store count
  always_ff @(posedge clk) begin
    if (cmd.cap_chan) begin
      frame_channel <= rx_byte;
    end
    if (cmd.cap_len_low) begin
      len_low <= rx_byte;
    end
    if (cmd.start_frame) begin
      frame_len  <= len_low[CW-1:0];
      stored_cnt <= '0;
    end else if (cmd.store_byte) begin
      stored_cnt <= stored_cnt + CW'(1);
    end
  end

  // payload buffer
  slfd_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (stored_cnt[AW-1:0]),
    .wdata (rx_byte),
    .re    (ren),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // replay: read data waits in the ram output until the result register takes it
  assign move = rd_pending && (!result_valid || !result_stall);
  assign ren  = cmd.replay_en && (!rd_pending || move);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx       <= '0;
      rd_pending   <= 1'b0;
      rd_last      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ren) begin
        rd_pending <= 1'b1;
        rd_last    <= idx_is_last;
        rd_idx     <= idx_is_last ? '0 : rd_idx + AW'(1);
      end else if (move) begin
        rd_pending <= 1'b0;
      end
      if (move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (move) begin
      result.payload_byte <= rd_data;
      result.frame_last   <= rd_last;
    end
  end

endmodule

`default_nettype wire

### sv/sync_length_frame_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Deframer for a byte stream: hunts for a two-byte sync word, then takes a
// channel byte and a 16-bit little-endian length, stores the payload in a
// PAYLOAD_DEPTH-byte buffer and, for frames on the forwarded channel, replays
// it as result beats with frame_last on the final byte. Frames with a zero
// length or one above the limit are dropped; a link-lost beat returns to
// hunting. Input beats are taken one per cycle except during replay: after the
// last byte of a forwarded frame the input is stalled while the payload is
// read back through the buffer's single read port, and the read-back waits
// while the result side stalls.
// No clearing pass is needed after reset.

module sync_length_frame_deframer_core
  import slfd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  slfd_in_t   item,
  output logic       result_valid,
  input  logic       result_stall,
  output slfd_out_t  result,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  slfd_cmd_t cmd;
  slfd_sts_t sts;

  // frame state machine
  slfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (item.opcode),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // registers, buffer and replay
  slfd_datapath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (item.rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slfd_pkg::*;

  localparam int DEPTH         = PAYLOAD_DEPTH_DEF;
  localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDLE_PCT      = 24;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 200000;

  // deframer phases as the predictor tracks them
  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_CHANNEL, TAKE_LEN_LO, TAKE_LEN_HI, TAKE_PAYLOAD
  } frame_phase_e;

  // directed rows: predicted, typed no-result, typed single last byte, register write
  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_LAST, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] idx;
    slfd_in_t   beat;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  slfd_in_t   item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  slfd_out_t  result;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // register mirror
  logic [7:0] sync_first_r  = SYNC_FIRST_RST;
  logic [7:0] sync_second_r = SYNC_SECOND_RST;
  logic [7:0] fwd_channel_r = FWD_CHANNEL_RST;
  logic [6:0] limit_r       = LENGTH_LIMIT_RST;

  // predictor state
  frame_phase_e phase_r  = HUNT_FIRST;
  logic [7:0]   chan_r   = '0;
  logic [15:0]  flen_r   = '0;
  logic [6:0]   stored_r = '0;
  logic [7:0]   store_r [DEPTH];

  slfd_out_t replay_new[$];
  slfd_out_t replay_expected[$];
  stim_row_t directed_rows[$];
  slfd_out_t want;

  int  fail_count  = 0;
  int  beats_sent  = 0;
  int  cycle_count = 0;
  int  hold_left   = 0;
  bit  calm        = 1'b0;
  bit  hold_armed  = 1'b0;
  logic [7:0] pick_sync;

  sync_length_frame_deframer_core #(
    .PAYLOAD_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // next state of the deframer for one beat, forwarded payload into replay_new
  function automatic void deframe_beat(slfd_in_t beat);
    int lim;
    int n;
    int i;
    lim = (int'(limit_r) > DEPTH) ? DEPTH : int'(limit_r);
    if (beat.opcode == OP_LINK_LOST) begin
      phase_r = HUNT_FIRST;
      return;
    end
    case (phase_r)
      HUNT_SECOND: begin
        // second byte wins over a repeated first byte
        if (beat.rx_byte == sync_second_r) phase_r = TAKE_CHANNEL;
        else if (beat.rx_byte == sync_first_r) phase_r = HUNT_SECOND;
        else phase_r = HUNT_FIRST;
      end
      TAKE_CHANNEL: begin
        chan_r = beat.rx_byte;
        phase_r = TAKE_LEN_LO;
      end
      TAKE_LEN_LO: begin
        flen_r = {8'h00, beat.rx_byte};
        phase_r = TAKE_LEN_HI;
      end
      TAKE_LEN_HI: begin
        flen_r[15:8] = beat.rx_byte;
        stored_r = '0;
        phase_r = (flen_r == 0 || flen_r > lim) ? HUNT_FIRST : TAKE_PAYLOAD;
      end
      TAKE_PAYLOAD: begin
        if (int'(stored_r) < DEPTH) store_r[IDX_W'(stored_r)] = beat.rx_byte;
        stored_r = stored_r + 1'b1;
        if (stored_r >= flen_r) begin
          if (chan_r == fwd_channel_r) begin
            n = (int'(flen_r) > DEPTH) ? DEPTH : int'(flen_r);
            for (i = 0; i < n; i++)
              replay_new.push_back({store_r[IDX_W'(i)], (i + 1 == n) ? 1'b1 : 1'b0});
          end
          phase_r = HUNT_FIRST;
        end
      end
      default: phase_r = (beat.rx_byte == sync_first_r) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endfunction

  // log what an accepted beat should produce
  function automatic void book_beat(slfd_in_t beat, row_kind_e kind);
    replay_new.delete();
    deframe_beat(beat);
    case (kind)
      ROW_NONE: ;
      ROW_LAST: replay_expected.push_back({beat.rx_byte, 1'b1});
      default: foreach (replay_new[k]) replay_expected.push_back(replay_new[k]);
    endcase
  endfunction

  function automatic stim_row_t row_of(row_kind_e kind, logic [1:0] idx, logic op,
                                       logic [7:0] data);
    stim_row_t r;
    r.kind = kind;
    r.idx = idx;
    r.beat.opcode = op;
    r.beat.rx_byte = data;
    return r;
  endfunction

  // offer one input beat, with random gaps ahead of it
  task automatic send_beat(input slfd_in_t beat, input row_kind_e kind);
    bit taken;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= beat;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !item_stall;
      if (taken) begin
        book_beat(beat, kind);
        beats_sent++;
      end
      @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] data);
    slfd_in_t beat;
    beat.opcode = OP_BYTE;
    beat.rx_byte = data;
    send_beat(beat, ROW_PRED);
  endtask

  // leaves cfg_write high; caller lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SYNC_FIRST:   sync_first_r = data;
      REG_SYNC_SECOND:  sync_second_r = data;
      REG_FWD_CHANNEL:  fwd_channel_r = data;
      REG_LENGTH_LIMIT: limit_r = data[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain all results, then give the block time to settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (replay_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one frame, mostly well formed, with noise, bad lengths and cut payloads
  task automatic send_random_frame();
    int eff;
    int pick;
    int cut;
    int i;
    logic [15:0] flen;
    logic [7:0] chan;
    slfd_in_t noise;
    eff = (int'(limit_r) > DEPTH) ? DEPTH : int'(limit_r);
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 1)) begin
        noise.opcode = ($urandom_range(9) < 3) ? OP_LINK_LOST : OP_BYTE;
        noise.rx_byte = 8'($urandom_range(255));
        send_beat(noise, ROW_PRED);
      end
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) send_byte(sync_first_r);
    send_byte(sync_first_r);
    send_byte(sync_second_r);
    chan = ($urandom_range(9) < 8) ? fwd_channel_r : 8'($urandom_range(255));
    send_byte(chan);
    pick = int'($urandom_range(99));
    if (pick < 6) flen = '0;
    else if (pick < 12) flen = 16'(eff + int'($urandom_range(8, 1)));
    else if (pick < 16) flen = 16'($urandom_range(16'hFFFF, 256));
    else if (pick < 20) flen = 16'((eff > 0) ? eff : 1);
    else flen = 16'($urandom_range((eff > 8 || eff == 0) ? 8 : eff, 1));
    send_byte(flen[7:0]);
    send_byte(flen[15:8]);
    if (flen == 0 || flen > eff) return;
    cut = ($urandom_range(99) < 6) ? int'($urandom_range(int'(flen) - 1)) : int'(flen);
    for (i = 0; i < flen; i++) begin
      if (i == cut) begin
        noise.opcode = OP_LINK_LOST;
        noise.rx_byte = 8'($urandom_range(255));
        send_beat(noise, ROW_PRED);
        return;
      end
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input logic [7:0] sf, input logic [7:0] ss, input logic [7:0] ch,
                           input logic [7:0] lim, input int budget);
    int start;
    wait_idle();
    write_reg(REG_SYNC_FIRST, sf);
    write_reg(REG_SYNC_SECOND, ss);
    write_reg(REG_FWD_CHANNEL, ch);
    write_reg(REG_LENGTH_LIMIT, lim);
    cfg_write <= 1'b0;
    start = beats_sent;
    while (beats_sent - start < budget) send_random_frame();
  endtask

  // result side: random stalls, one long hold-off when armed
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (hold_armed && replay_expected.size() != 0) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // compare each accepted result beat with the oldest expectation
  always @(negedge clk) begin
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (replay_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: byte %02h last %0d",
                   result.payload_byte, result.frame_last);
      end else begin
        want = replay_expected.pop_front();
        if (result.payload_byte !== want.payload_byte ||
            result.frame_last !== want.frame_last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                     want.payload_byte, want.frame_last,
                     result.payload_byte, result.frame_last);
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    // reset values: sync 00 00, channel 00, limit 64
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h01));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_LAST, REG_SYNC_FIRST, OP_BYTE, 8'hFF));
    // link lost while hunting, byte ignored
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_LINK_LOST, 8'hFF));
    directed_rows.push_back(row_of(ROW_CFG, REG_SYNC_FIRST, OP_BYTE, 8'hA5));
    directed_rows.push_back(row_of(ROW_CFG, REG_SYNC_SECOND, OP_BYTE, 8'h5A));
    directed_rows.push_back(row_of(ROW_CFG, REG_LENGTH_LIMIT, OP_BYTE, 8'h02));
    // repeated first sync byte, then link lost inside the header
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'hA5));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'hA5));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h5A));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_LINK_LOST, 8'h00));
    // zero length frame is dropped
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'hA5));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h5A));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    // two byte frame at the limit
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'hA5));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h5A));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h02));
    directed_rows.push_back(row_of(ROW_NONE, REG_SYNC_FIRST, OP_BYTE, 8'h00));
    directed_rows.push_back(row_of(ROW_PRED, REG_SYNC_FIRST, OP_BYTE, 8'h80));
    directed_rows.push_back(row_of(ROW_PRED, REG_SYNC_FIRST, OP_BYTE, 8'h7F));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[r].idx, directed_rows[r].beat.rx_byte);
        cfg_write <= 1'b0;
      end else begin
        send_beat(directed_rows[r].beat, directed_rows[r].kind);
      end
    end

    // random phases over several register settings
    run_phase(8'h00, 8'hFF, 8'hFF, 8'd127, 35);
    calm = 1'b1;
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'd64, 35);
    calm = 1'b0;
    hold_armed = 1'b1;
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(64, 1)), 40);
    run_phase(8'hFF, 8'h00, 8'h00, 8'd1, 30);
    pick_sync = 8'($urandom_range(255));
    run_phase(pick_sync, pick_sync, 8'($urandom_range(255)), 8'd0, 15);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255, 65)), 45);

    // drain and finish
    item_valid <= 1'b0;
    while (replay_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
